### rtl/vlw_pkg.sv
// Package for the voxel line walker: field widths, default map sizes,
// axis codes and the request/response types of the shared divider.
// No dependencies.
package vlw_pkg;

  // Field widths of the input and result items.
  localparam int XY_W = 9;
  localparam int Z_W  = 6;

  // Default map geometry and run length.
  localparam int MAP_SIDE_DEF   = 512;
  localparam int MAP_HEIGHT_DEF = 64;
  localparam int MAX_VOXELS_DEF = 64;

  // Error increment of the major axis, as a shift and as a value.
  localparam int INC_MAJOR_SHIFT = 10;
  localparam int INC_MAJOR       = 1 << INC_MAJOR_SHIFT;

  // Numerator of the increment given to an axis that does not move.
  localparam int INC_NONE_NUM = 32'h3fff_ffff;

  // Absolute distances fit the widest coordinate field.
  localparam int DIST_W = XY_W;
  localparam int DVD_W  = DIST_W + INC_MAJOR_SHIFT;
  localparam int DIV_CNT_W = $clog2(DVD_W);

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DIST_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

### rtl/vlw_line_if.sv
// Input channel of the voxel line walker: one item is a start and an end voxel.
// Depends on vlw_pkg for the field widths.
interface vlw_line_if;
  logic                      valid;
  logic                      ready;
  logic [vlw_pkg::XY_W-1:0]  start_x;
  logic [vlw_pkg::XY_W-1:0]  start_y;
  logic [vlw_pkg::Z_W-1:0]   start_z;
  logic [vlw_pkg::XY_W-1:0]  end_x;
  logic [vlw_pkg::XY_W-1:0]  end_y;
  logic [vlw_pkg::Z_W-1:0]   end_z;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                output ready);
endinterface

### rtl/vlw_voxel_if.sv
// Output channel of the voxel line walker: one item is one visited voxel.
// Depends on vlw_pkg for the field widths.
interface vlw_voxel_if;
  logic                      valid;
  logic                      ready;
  logic [vlw_pkg::XY_W-1:0]  vox_x;
  logic [vlw_pkg::XY_W-1:0]  vox_y;
  logic [vlw_pkg::Z_W-1:0]   vox_z;
  logic                      last;

  modport source (output valid, vox_x, vox_y, vox_z, last, input ready);
  modport sink (input valid, vox_x, vox_y, vox_z, last, output ready);
endinterface

### rtl/vlw_divider.sv
// Restoring divider shared by the increment setup: one quotient bit a cycle.
// Depends on vlw_pkg for widths and the request/response structs.
module vlw_divider (
  input  logic              clk,
  input  logic              rst,
  input  vlw_pkg::div_req_t req,
  output vlw_pkg::div_rsp_t rsp
);

  logic                               busy;
  logic [vlw_pkg::DIV_CNT_W-1:0]      bit_cnt;
  logic [vlw_pkg::DIST_W-1:0]         rem;
  logic [vlw_pkg::DVD_W-1:0]          quo;
  logic [vlw_pkg::DIST_W-1:0]         dvs;
  logic                               done;
  logic [vlw_pkg::DIST_W:0]           rem_sh;
  logic [vlw_pkg::DIST_W:0]           rem_sub;
  logic                               fits;

  // The dividend shifts out of the top of quo while quotient bits shift in.
  always_comb begin
    rem_sh  = {rem, quo[vlw_pkg::DVD_W-1]};
    rem_sub = rem_sh - {1'b0, dvs};
    fits    = rem_sh >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      bit_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        bit_cnt <= '0;
        rem     <= '0;
        quo     <= req.dividend;
        dvs     <= req.divisor;
      end else if (busy) begin
        rem <= fits ? rem_sub[vlw_pkg::DIST_W-1:0] : rem_sh[vlw_pkg::DIST_W-1:0];
        quo <= {quo[vlw_pkg::DVD_W-2:0], fits};
        if (bit_cnt == vlw_pkg::DIV_CNT_W'(vlw_pkg::DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          bit_cnt <= bit_cnt + 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

### rtl/voxel_line_walker.sv
// Voxel line walker: walks a 3D line between two voxels and emits each voxel.
// Uses vlw_pkg, vlw_line_if, vlw_voxel_if and vlw_divider.
//
// The line channel takes one item, a start and an end voxel; endpoints beyond
// the map are limited to its edge. The voxel channel then gives one item per
// visited voxel, the start voxel first, and marks the final one with last.
// A run ends at the end voxel, after MAX_VOXELS items, or where the next step
// would leave the map.
//
// line.ready is high only while the block is idle. After an item is taken,
// setup chooses the major axis, then gets two quotients from the shared
// one-bit-a-cycle divider (an axis of zero distance skips its division), then
// loads the error counters. Each voxel is then offered for one cycle at best.
// The voxel payload comes straight from the walk registers, and a stall on
// the voxel channel simply holds the walk. Synchronous reset returns the
// block to idle with no voxel pending.
module voxel_line_walker #(
  parameter int MAP_SIDE   = vlw_pkg::MAP_SIDE_DEF,
  parameter int MAP_HEIGHT = vlw_pkg::MAP_HEIGHT_DEF,
  parameter int MAX_VOXELS = vlw_pkg::MAX_VOXELS_DEF
) (
  input logic        clk,
  input logic        rst,
  vlw_line_if.sink   line,
  vlw_voxel_if.source voxel
);

  localparam int INC_NONE   = vlw_pkg::INC_NONE_NUM / MAP_SIDE;
  localparam int INC_NONE_W = $clog2(INC_NONE + 1);
  localparam int INC_W      = (INC_NONE_W > vlw_pkg::DVD_W) ? INC_NONE_W : vlw_pkg::DVD_W;
  localparam int CNT_W      = INC_W + $clog2(MAX_VOXELS) + 1;
  localparam int CUR_W      = $clog2(MAP_SIDE + MAP_HEIGHT + MAX_VOXELS) + 1;
  localparam int EMIT_W     = $clog2(MAX_VOXELS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAJOR,
    S_DIV_GO,
    S_DIV_WAIT,
    S_INIT,
    S_WALK
  } state_t;

  typedef logic signed [CUR_W-1:0] coord_t;

  state_t                      state;
  coord_t                      cur [3];
  coord_t                      tgt [3];
  logic                        neg [3];
  logic [vlw_pkg::DIST_W-1:0]  adist [3];
  logic [INC_W-1:0]            inc [3];
  logic [CNT_W-1:0]            err [3];
  vlw_pkg::axis_t              major;
  logic                        minor_sel;
  logic [EMIT_W-1:0]           emitted;

  vlw_pkg::div_req_t           div_req;
  vlw_pkg::div_rsp_t           div_rsp;

  coord_t                      in_start [3];
  coord_t                      in_end [3];
  coord_t                      in_dist [3];
  vlw_pkg::axis_t              minor_ax;
  vlw_pkg::axis_t              step_ax;
  coord_t                      step_next;
  logic                        at_end;
  logic                        off_map;
  logic                        run_last;
  logic [INC_W-1:0]            half_inc [3];

  function automatic coord_t clamp_coord(input logic [vlw_pkg::XY_W-1:0] v,
                                         input int limit);
    if (int'(v) > limit - 1) begin
      return CUR_W'(limit - 1);
    end
    return CUR_W'(v);
  endfunction

  vlw_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Limited endpoints and signed distances of the item on the line channel.
  always_comb begin
    in_start[0] = clamp_coord(line.start_x, MAP_SIDE);
    in_start[1] = clamp_coord(line.start_y, MAP_SIDE);
    in_start[2] = clamp_coord(vlw_pkg::XY_W'(line.start_z), MAP_HEIGHT);
    in_end[0]   = clamp_coord(line.end_x, MAP_SIDE);
    in_end[1]   = clamp_coord(line.end_y, MAP_SIDE);
    in_end[2]   = clamp_coord(vlw_pkg::XY_W'(line.end_z), MAP_HEIGHT);
    for (int k = 0; k < 3; k++) begin
      in_dist[k] = in_end[k] - in_start[k];
    end
  end

  // The two minor axes are handled in axis order.
  always_comb begin
    if (!minor_sel) begin
      minor_ax = (major == vlw_pkg::AXIS_X) ? vlw_pkg::AXIS_Y : vlw_pkg::AXIS_X;
    end else begin
      minor_ax = (major == vlw_pkg::AXIS_Z) ? vlw_pkg::AXIS_Y : vlw_pkg::AXIS_Z;
    end
    for (int k = 0; k < 3; k++) begin
      half_inc[k] = inc[k] >> 1;
    end
  end

  // Step decision: z wins ties against both others, then x only if strictly below y.
  always_comb begin
    if (err[2] <= err[0] && err[2] <= err[1]) begin
      step_ax = vlw_pkg::AXIS_Z;
    end else if (err[0] < err[1]) begin
      step_ax = vlw_pkg::AXIS_X;
    end else begin
      step_ax = vlw_pkg::AXIS_Y;
    end
    step_next = neg[step_ax] ? cur[step_ax] - coord_t'(1) : cur[step_ax] + coord_t'(1);
    if (step_ax == vlw_pkg::AXIS_Z) begin
      off_map = (step_next < 0) || (step_next >= coord_t'(MAP_HEIGHT));
    end else begin
      off_map = (step_next < 0) || (step_next >= coord_t'(MAP_SIDE));
    end
    at_end   = (cur[0] == tgt[0]) && (cur[1] == tgt[1]) && (cur[2] == tgt[2]);
    run_last = (emitted == EMIT_W'(MAX_VOXELS - 1)) || at_end || off_map;
  end

  always_comb begin
    div_req.start    = (state == S_DIV_GO) && (adist[minor_ax] != '0);
    div_req.dividend = {adist[major], {vlw_pkg::INC_MAJOR_SHIFT{1'b0}}};
    div_req.divisor  = adist[minor_ax];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      minor_sel <= 1'b0;
      emitted   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (line.valid) begin
            for (int k = 0; k < 3; k++) begin
              cur[k]   <= in_start[k];
              tgt[k]   <= in_end[k];
              neg[k]   <= in_dist[k] < 0;
              adist[k] <= vlw_pkg::DIST_W'((in_dist[k] < 0) ? -in_dist[k] : in_dist[k]);
            end
            state <= S_MAJOR;
          end
        end
        S_MAJOR: begin
          minor_sel <= 1'b0;
          if (adist[0] >= adist[1] && adist[0] >= adist[2]) begin
            major  <= vlw_pkg::AXIS_X;
            inc[0] <= INC_W'(vlw_pkg::INC_MAJOR);
          end else if (adist[1] >= adist[2]) begin
            major  <= vlw_pkg::AXIS_Y;
            inc[1] <= INC_W'(vlw_pkg::INC_MAJOR);
          end else begin
            major  <= vlw_pkg::AXIS_Z;
            inc[2] <= INC_W'(vlw_pkg::INC_MAJOR);
          end
          state <= S_DIV_GO;
        end
        S_DIV_GO: begin
          if (adist[minor_ax] == '0) begin
            inc[minor_ax] <= INC_W'(INC_NONE);
            minor_sel     <= 1'b1;
            state         <= minor_sel ? S_INIT : S_DIV_GO;
          end else begin
            state <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            inc[minor_ax] <= INC_W'(div_rsp.quotient);
            minor_sel     <= 1'b1;
            state         <= minor_sel ? S_INIT : S_DIV_GO;
          end
        end
        S_INIT: begin
          for (int k = 0; k < 3; k++) begin
            err[k] <= neg[k] ? CNT_W'(half_inc[k]) : CNT_W'(inc[k] - half_inc[k]);
          end
          emitted <= '0;
          state   <= S_WALK;
        end
        S_WALK: begin
          if (voxel.ready) begin
            if (run_last) begin
              state <= S_IDLE;
            end else begin
              cur[step_ax] <= step_next;
              err[step_ax] <= err[step_ax] + CNT_W'(inc[step_ax]);
              emitted      <= emitted + 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign line.ready  = (state == S_IDLE);
  assign voxel.valid = (state == S_WALK);
  assign voxel.vox_x = vlw_pkg::XY_W'(cur[0]);
  assign voxel.vox_y = vlw_pkg::XY_W'(cur[1]);
  assign voxel.vox_z = vlw_pkg::Z_W'(cur[2]);
  assign voxel.last  = run_last;

endmodule

### test/tb_top.sv
// Self-checking testbench for voxel_line_walker: random and directed line items
// are predicted voxel by voxel by a scoreboard class and checked in order.
// Depends on vlw_pkg, vlw_line_if, vlw_voxel_if and the voxel_line_walker RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAP_SIDE    = vlw_pkg::MAP_SIDE_DEF;
  localparam int MAP_HEIGHT  = vlw_pkg::MAP_HEIGHT_DEF;
  localparam int MAX_VOXELS  = vlw_pkg::MAX_VOXELS_DEF;
  localparam int XY_MAX      = (1 << vlw_pkg::XY_W) - 1;
  localparam int Z_MAX       = (1 << vlw_pkg::Z_W) - 1;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 100;

  typedef struct packed {
    logic [vlw_pkg::XY_W-1:0] x;
    logic [vlw_pkg::XY_W-1:0] y;
    logic [vlw_pkg::Z_W-1:0]  z;
    logic                     last;
  } voxel_t;

  class voxel_scoreboard;
    voxel_t      voxel_q[$];
    int unsigned errors;
    int unsigned walks;
    int unsigned checked;
    // Walk state of the predictor.
    int     cur[3];
    longint err_cnt[3];
    longint err_inc[3];
    bit     neg[3];

    function int limit_coord(int v, int side);
      return (v > side - 1) ? side - 1 : v;
    endfunction

    function int pending();
      return voxel_q.size();
    endfunction

    // Works out every voxel that one accepted line item gives.
    function void walk_line(int sx, int sy, int sz, int ex, int ey, int ez);
      int             tgt[3];
      longint         delta[3];
      longint         mag[3];
      vlw_pkg::axis_t major;
      vlw_pkg::axis_t ax;
      int             k;
      int             n;
      int             nxt;
      int             side;
      bit             done;
      voxel_t         v;
      walks++;
      cur[vlw_pkg::AXIS_X] = limit_coord(sx, MAP_SIDE);
      cur[vlw_pkg::AXIS_Y] = limit_coord(sy, MAP_SIDE);
      cur[vlw_pkg::AXIS_Z] = limit_coord(sz, MAP_HEIGHT);
      tgt[vlw_pkg::AXIS_X] = limit_coord(ex, MAP_SIDE);
      tgt[vlw_pkg::AXIS_Y] = limit_coord(ey, MAP_SIDE);
      tgt[vlw_pkg::AXIS_Z] = limit_coord(ez, MAP_HEIGHT);
      for (k = 0; k < 3; k++) begin
        delta[k] = tgt[k] - cur[k];
        mag[k]   = (delta[k] < 0) ? -delta[k] : delta[k];
      end
      if (mag[vlw_pkg::AXIS_X] >= mag[vlw_pkg::AXIS_Y] &&
          mag[vlw_pkg::AXIS_X] >= mag[vlw_pkg::AXIS_Z]) begin
        major = vlw_pkg::AXIS_X;
      end else if (mag[vlw_pkg::AXIS_Y] >= mag[vlw_pkg::AXIS_Z]) begin
        major = vlw_pkg::AXIS_Y;
      end else begin
        major = vlw_pkg::AXIS_Z;
      end
      for (k = 0; k < 3; k++) begin
        if (k == int'(major)) begin
          err_inc[k] = vlw_pkg::INC_MAJOR;
        end else if (delta[k] == 0) begin
          err_inc[k] = vlw_pkg::INC_NONE_NUM / MAP_SIDE;
        end else begin
          err_inc[k] = (mag[major] * vlw_pkg::INC_MAJOR) / mag[k];
        end
        neg[k]     = (delta[k] < 0);
        err_cnt[k] = neg[k] ? err_inc[k] / 2 : err_inc[k] - err_inc[k] / 2;
      end

      n    = 0;
      done = 1'b0;
      while (!done) begin
        v.x    = vlw_pkg::XY_W'(cur[vlw_pkg::AXIS_X]);
        v.y    = vlw_pkg::XY_W'(cur[vlw_pkg::AXIS_Y]);
        v.z    = vlw_pkg::Z_W'(cur[vlw_pkg::AXIS_Z]);
        v.last = 1'b0;
        voxel_q.push_back(v);
        n++;
        if (n >= MAX_VOXELS) begin
          done = 1'b1;
        end else if (cur[vlw_pkg::AXIS_X] == tgt[vlw_pkg::AXIS_X] &&
                     cur[vlw_pkg::AXIS_Y] == tgt[vlw_pkg::AXIS_Y] &&
                     cur[vlw_pkg::AXIS_Z] == tgt[vlw_pkg::AXIS_Z]) begin
          done = 1'b1;
        end else begin
          if (err_cnt[vlw_pkg::AXIS_Z] <= err_cnt[vlw_pkg::AXIS_X] &&
              err_cnt[vlw_pkg::AXIS_Z] <= err_cnt[vlw_pkg::AXIS_Y]) begin
            ax = vlw_pkg::AXIS_Z;
          end else if (err_cnt[vlw_pkg::AXIS_X] < err_cnt[vlw_pkg::AXIS_Y]) begin
            ax = vlw_pkg::AXIS_X;
          end else begin
            ax = vlw_pkg::AXIS_Y;
          end
          side = (ax == vlw_pkg::AXIS_Z) ? MAP_HEIGHT : MAP_SIDE;
          nxt  = cur[ax] + (neg[ax] ? -1 : 1);
          // A step off the map ends the run on the voxel already emitted.
          if (nxt < 0 || nxt >= side) begin
            done = 1'b1;
          end else begin
            cur[ax]     = nxt;
            err_cnt[ax] = err_cnt[ax] + err_inc[ax];
          end
        end
      end
      v      = voxel_q.pop_back();
      v.last = 1'b1;
      voxel_q.push_back(v);
    endfunction

    function void check_voxel(voxel_t got);
      voxel_t want;
      checked++;
      if (voxel_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected voxel, expected none, got (%0d,%0d,%0d) last=%0d",
                 $time, got.x, got.y, got.z, got.last);
        return;
      end
      want = voxel_q.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
          got.last !== want.last) begin
        errors++;
        $display("%0t: voxel mismatch, expected (%0d,%0d,%0d) last=%0d, got (%0d,%0d,%0d) last=%0d",
                 $time, want.x, want.y, want.z, want.last, got.x, got.y, got.z, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  vlw_line_if  line_ch();
  vlw_voxel_if voxel_ch();

  voxel_line_walker dut (
    .clk   (clk),
    .rst   (rst),
    .line  (line_ch),
    .voxel (voxel_ch)
  );

  voxel_scoreboard sb = new();

  int tx_idle_pct;
  int rx_idle_pct;
  int hold_requests;
  int holds_started = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  int directed_lines;
  voxel_t seen;

  always #1 clk = ~clk;

  // Receiver: random back-pressure, plus long hold-offs on request.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      voxel_ch.ready = 1'b0;
      hold_left--;
    end else if (holds_started < hold_requests) begin
      voxel_ch.ready = 1'b0;
      hold_left = HOLD_CYCLES - 1;
      holds_started++;
    end else begin
      voxel_ch.ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor and watchdog, sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (line_ch.valid && line_ch.ready) begin
        sb.walk_line(line_ch.start_x, line_ch.start_y, line_ch.start_z,
                     line_ch.end_x, line_ch.end_y, line_ch.end_z);
      end
      if (voxel_ch.valid && voxel_ch.ready) begin
        seen.x    = voxel_ch.vox_x;
        seen.y    = voxel_ch.vox_y;
        seen.z    = voxel_ch.vox_z;
        seen.last = voxel_ch.last;
        sb.check_voxel(seen);
      end
      if ((line_ch.valid && line_ch.ready) || (voxel_ch.valid && voxel_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
          $display("FAILED: results differ");
          $finish;
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so a following item goes out back to back.
  task automatic send_line(int sx, int sy, int sz, int ex, int ey, int ez);
    while ($urandom_range(99) < tx_idle_pct) begin
      line_ch.valid = 1'b0;
      @(negedge clk);
    end
    line_ch.valid   = 1'b1;
    line_ch.start_x = sx[vlw_pkg::XY_W-1:0];
    line_ch.start_y = sy[vlw_pkg::XY_W-1:0];
    line_ch.start_z = sz[vlw_pkg::Z_W-1:0];
    line_ch.end_x   = ex[vlw_pkg::XY_W-1:0];
    line_ch.end_y   = ey[vlw_pkg::XY_W-1:0];
    line_ch.end_z   = ez[vlw_pkg::Z_W-1:0];
    @(posedge clk);
    while (!line_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_for_voxels();
    line_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Endpoints and edges of the map turn up more often than uniform draws give.
  function automatic int pick_coord(int hi);
    int r;
    r = $urandom_range(7);
    if (r == 0) return 0;
    if (r == 1) return hi;
    return $urandom_range(hi);
  endfunction

  function automatic int near_coord(int c, int span, int hi);
    int v;
    v = c + $urandom_range(2 * span) - span;
    if (v < 0) v = 0;
    if (v > hi) v = hi;
    return v;
  endfunction

  task automatic send_random();
    int sx;
    int sy;
    int sz;
    int kind;
    sx   = pick_coord(XY_MAX);
    sy   = pick_coord(XY_MAX);
    sz   = pick_coord(Z_MAX);
    kind = $urandom_range(19);
    if (kind == 0) begin
      send_line(sx, sy, sz, sx, sy, sz);
    end else if (kind < 7) begin
      send_line(sx, sy, sz, pick_coord(XY_MAX), pick_coord(XY_MAX), pick_coord(Z_MAX));
    end else if (kind < 10) begin
      // Mostly along one axis, to stress the minor-axis increments.
      send_line(sx, sy, sz, near_coord(sx, 60, XY_MAX), near_coord(sy, 3, XY_MAX),
                near_coord(sz, 2, Z_MAX));
    end else begin
      send_line(sx, sy, sz, near_coord(sx, 30, XY_MAX), near_coord(sy, 30, XY_MAX),
                near_coord(sz, 20, Z_MAX));
    end
  endtask

  initial begin
    int i;
    clk             = 1'b0;
    rst             = 1'b1;
    line_ch.valid   = 1'b0;
    line_ch.start_x = '0;
    line_ch.start_y = '0;
    line_ch.start_z = '0;
    line_ch.end_x   = '0;
    line_ch.end_y   = '0;
    line_ch.end_z   = '0;
    tx_idle_pct     = 14;
    rx_idle_pct     = 81;
    hold_requests   = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Directed items: single voxels, long capped runs, axis ties, single-axis
    // lines, map corners and alternating bit patterns.
    send_line(0, 0, 0, 0, 0, 0);
    send_line(XY_MAX, XY_MAX, Z_MAX, XY_MAX, XY_MAX, Z_MAX);
    send_line(0, 0, 0, XY_MAX, XY_MAX, Z_MAX);
    send_line(XY_MAX, XY_MAX, Z_MAX, 0, 0, 0);
    send_line(10, 10, 10, 30, 30, 10);
    send_line(10, 10, 10, 12, 30, 30);
    send_line(20, 20, 5, 20, 20, 60);
    send_line(300, 40, 30, 300, 90, 30);
    send_line(200, 200, 32, 170, 200, 32);
    send_line(100, 100, 0, 110, 105, 50);
    send_line(0, XY_MAX, Z_MAX, 40, 480, 55);
    send_line(XY_MAX, 0, 0, 480, 25, 9);
    send_line(5, 5, 5, 6, 5, 5);
    send_line(5, 5, 5, 5, 5, 4);
    send_line(256, 255, 31, 257, 254, 32);
    send_line(0, 0, Z_MAX, 100, 0, 62);
    send_line(XY_MAX, XY_MAX, 0, XY_MAX, 450, 1);
    send_line(170, 85, 42, 341, 426, 21);
    send_line(341, 426, 21, 170, 85, 42);
    directed_lines = 19;

    // The output stalls for a long stretch while items keep being offered.
    hold_requests++;
    for (i = 0; i < 100; i++) send_random();

    tx_idle_pct = 81;
    rx_idle_pct = 14;
    for (i = 0; i < 50; i++) send_random();
    wait_for_voxels();
    for (i = 0; i < 50; i++) send_random();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (i = 0; i < 100; i++) send_random();

    wait_for_voxels();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.pending() != 0) begin
      sb.errors += sb.pending();
      $display("%0t: %0d expected voxels never arrived", $time, sb.pending());
    end

    $display("Walked %0d lines (%0d directed) and checked %0d voxels, %0d wrong,",
             sb.walks, directed_lines, sb.checked, sb.errors);
    $display("under three idling mixes, one long output hold-off and one drain pause.");
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
